// File: hdl/gra_pkg.sv
// glue register arithmetic: shared constants, opcodes, glue record and
// controller/datapath command types
// no dependencies
`default_nettype none

package gra_pkg;

    localparam int NUM_REGS = 256;
    localparam int IDX_W    = (NUM_REGS > 1) ? $clog2(NUM_REGS) : 1;

    localparam int COMP_W   = 32;
    localparam int IN_W     = 31;
    localparam int ORD_W    = 2;
    localparam int LIMIT_W  = 31;
    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 31'd1073741823;

    localparam int NUM_COMP  = 3;
    localparam int MUL_STEPS = 2 * NUM_COMP;
    localparam int DIV_STEPS = COMP_W;
    localparam int CNT_W     = $clog2(DIV_STEPS);

    localparam logic [2:0] OP_ASSIGN   = 3'd0;
    localparam logic [2:0] OP_READ     = 3'd1;
    localparam logic [2:0] OP_ADVANCE  = 3'd2;
    localparam logic [2:0] OP_MULTIPLY = 3'd3;
    localparam logic [2:0] OP_DIVIDE   = 3'd4;

    typedef struct packed {
        logic [COMP_W-1:0] width;
        logic [COMP_W-1:0] stretch;
        logic [ORD_W-1:0]  stretch_order;
        logic [COMP_W-1:0] shrink;
        logic [ORD_W-1:0]  shrink_order;
    } t_glue;

    typedef struct packed {
        logic [ORD_W-1:0]  ord;
        logic [COMP_W-1:0] amt;
    } t_part;

    typedef struct packed {
        logic       capture;
        logic       rd;
        logic       load;
        logic       mul_go;
        logic       mul_chk;
        logic [1:0] comp;
        logic       div_init;
        logic       div_step;
        logic       div_fin;
        logic       fin;
    } t_cmd;

    typedef struct packed {
        logic [2:0] op;
    } t_status;

    // keep the higher nonzero order; a zero amount drops back to finite
    function automatic t_part adv_part(input logic [COMP_W-1:0] amt,
                                       input logic [ORD_W-1:0]  ord,
                                       input logic [COMP_W-1:0] in_amt,
                                       input logic [ORD_W-1:0]  in_ord);
        t_part            r;
        logic [ORD_W-1:0] o;
        o     = (amt == '0) ? '0 : ord;
        r.amt = amt;
        r.ord = o;
        if (o == in_ord) begin
            r.amt = amt + in_amt;
        end else if (o < in_ord && in_amt != '0) begin
            r.amt = in_amt;
            r.ord = in_ord;
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// File: hdl/gra_ram.sv
// generic single-write, single-read ram with registered read data
// no dependencies
`default_nettype none

module gra_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic             i_re,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// File: hdl/gra_ctrl.sv
// glue register arithmetic controller: sequences read, execute and write-back
// depends on gra_pkg
`default_nettype none

module gra_ctrl (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_in_valid,
    output logic                 o_in_stall,
    output logic                 o_out_valid,
    input  wire logic            i_out_stall,
    input  wire gra_pkg::t_status i_status,
    output gra_pkg::t_cmd        o_cmd
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_RD    = 3'd1;
    localparam logic [2:0] S_LOAD  = 3'd2;
    localparam logic [2:0] S_MUL   = 3'd3;
    localparam logic [2:0] S_DINIT = 3'd4;
    localparam logic [2:0] S_DIV   = 3'd5;
    localparam logic [2:0] S_DFIN  = 3'd6;
    localparam logic [2:0] S_FIN   = 3'd7;

    logic [2:0]              r_state, n_state;
    logic [gra_pkg::CNT_W-1:0] r_cnt, n_cnt;
    logic                    r_out_valid, n_out_valid;
    gra_pkg::t_cmd           cmd;

    always_comb begin
        n_state     = r_state;
        n_cnt       = r_cnt;
        n_out_valid = r_out_valid & i_out_stall;
        cmd         = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    cmd.capture = 1'b1;
                    n_state     = S_RD;
                end
            end
            S_RD: begin
                cmd.rd  = 1'b1;
                n_state = S_LOAD;
            end
            S_LOAD: begin
                cmd.load = 1'b1;
                n_cnt    = '0;
                if (i_status.op == gra_pkg::OP_MULTIPLY) begin
                    n_state = S_MUL;
                end else if (i_status.op == gra_pkg::OP_DIVIDE) begin
                    n_state = S_DINIT;
                end else begin
                    n_state = S_FIN;
                end
            end
            S_MUL: begin
                // even count multiplies a component, odd count checks it
                cmd.comp    = r_cnt[2:1];
                cmd.mul_go  = ~r_cnt[0];
                cmd.mul_chk = r_cnt[0];
                if (r_cnt == gra_pkg::CNT_W'(gra_pkg::MUL_STEPS - 1)) begin
                    n_cnt   = '0;
                    n_state = S_FIN;
                end else begin
                    n_cnt = r_cnt + gra_pkg::CNT_W'(1);
                end
            end
            S_DINIT: begin
                cmd.div_init = 1'b1;
                n_cnt        = '0;
                n_state      = S_DIV;
            end
            S_DIV: begin
                cmd.div_step = 1'b1;
                if (r_cnt == gra_pkg::CNT_W'(gra_pkg::DIV_STEPS - 1)) begin
                    n_cnt   = '0;
                    n_state = S_DFIN;
                end else begin
                    n_cnt = r_cnt + gra_pkg::CNT_W'(1);
                end
            end
            S_DFIN: begin
                cmd.div_fin = 1'b1;
                n_state     = S_FIN;
            end
            S_FIN: begin
                // hold the finished item until the output register frees up
                if (!r_out_valid || !i_out_stall) begin
                    cmd.fin     = 1'b1;
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_cmd       = cmd;

endmodule

`default_nettype wire

// File: hdl/gra_dpath.sv
// glue register arithmetic datapath: register table, advance logic, shared
// multiplier, three-lane restoring divider and result register
// depends on gra_pkg and gra_ram
`default_nettype none

module gra_dpath (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire gra_pkg::t_cmd                 i_cmd,
    output gra_pkg::t_status                   o_status,
    input  wire logic [2:0]                    i_opcode,
    input  wire logic [7:0]                    i_reg_index,
    input  wire logic [gra_pkg::IN_W-1:0]      i_in_width,
    input  wire logic [gra_pkg::IN_W-1:0]      i_in_stretch,
    input  wire logic [gra_pkg::ORD_W-1:0]     i_in_stretch_order,
    input  wire logic [gra_pkg::IN_W-1:0]      i_in_shrink,
    input  wire logic [gra_pkg::ORD_W-1:0]     i_in_shrink_order,
    input  wire logic [gra_pkg::COMP_W-1:0]    i_factor,
    input  wire logic                          i_cfg_we,
    input  wire logic [gra_pkg::LIMIT_W-1:0]   i_cfg_data,
    output gra_pkg::t_glue                     o_res,
    output logic                               o_overflow
);

    localparam int W  = gra_pkg::COMP_W;
    localparam int NC = gra_pkg::NUM_COMP;

    // captured beat
    logic [2:0]                r_op;
    logic [gra_pkg::IDX_W-1:0] r_idx;
    gra_pkg::t_glue            r_in;
    logic [W-1:0]              r_factor;
    logic [gra_pkg::LIMIT_W-1:0] r_limit;

    // table and valid bits (entry not yet written reads as zero glue)
    logic [gra_pkg::NUM_REGS-1:0] r_vld;
    logic                         r_rd_vld;
    gra_pkg::t_glue               rd_data;
    gra_pkg::t_glue               base;
    gra_pkg::t_glue               simple;
    gra_pkg::t_part               adv_st, adv_sh;

    // working registers: component 0 width, 1 stretch, 2 shrink
    logic [W-1:0]               r_cur [NC];
    logic [W-1:0]               r_nxt [NC];
    logic [gra_pkg::ORD_W-1:0]  r_sto, r_sho;
    logic                       r_ovf;

    // multiplier
    logic [W-1:0]        m_x;
    logic signed [2*W-1:0] r_prod;
    logic signed [2*W-1:0] m_lim;
    logic                m_over;

    // divider lanes
    logic [W-1:0] r_rem [NC];
    logic [W-1:0] r_quo [NC];
    logic [W-1:0] d_mag;
    logic [W:0]   d_t   [NC];
    logic         d_ge  [NC];
    logic [W:0]   d_sub [NC];
    logic         d_neg [NC];
    logic [W-1:0] d_q   [NC];
    logic         d_over;

    gra_pkg::t_glue res;

    gra_ram #(
        .WIDTH ($bits(gra_pkg::t_glue)),
        .DEPTH (gra_pkg::NUM_REGS)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.fin),
        .i_waddr (r_idx),
        .i_wdata (res),
        .i_re    (i_cmd.rd),
        .i_raddr (r_idx),
        .o_rdata (rd_data)
    );

    always_comb begin
        base   = r_rd_vld ? rd_data : '0;
        adv_st = gra_pkg::adv_part(base.stretch, base.stretch_order,
                                   r_in.stretch, r_in.stretch_order);
        adv_sh = gra_pkg::adv_part(base.shrink, base.shrink_order,
                                   r_in.shrink, r_in.shrink_order);
        case (r_op)
            gra_pkg::OP_ASSIGN: begin
                simple = r_in;
            end
            gra_pkg::OP_ADVANCE: begin
                simple.width         = base.width + r_in.width;
                simple.stretch       = adv_st.amt;
                simple.stretch_order = adv_st.ord;
                simple.shrink        = adv_sh.amt;
                simple.shrink_order  = adv_sh.ord;
            end
            default: begin
                simple = base;
            end
        endcase
    end

    always_comb begin
        case (i_cmd.comp)
            2'd0:    m_x = r_cur[0];
            2'd1:    m_x = r_cur[1];
            default: m_x = r_cur[2];
        endcase
        m_lim  = $signed({{(2*W-gra_pkg::LIMIT_W){1'b0}}, r_limit});
        m_over = (r_prod > m_lim) || (r_prod < -m_lim);
    end

    always_comb begin
        d_mag  = r_factor[W-1] ? -r_factor : r_factor;
        d_over = (r_factor == '0);
        for (int k = 0; k < NC; k++) begin
            d_t[k]   = {r_rem[k], r_quo[k][W-1]};
            d_ge[k]  = (d_t[k] >= {1'b0, d_mag});
            d_sub[k] = d_t[k] - {1'b0, d_mag};
            d_neg[k] = r_cur[k][W-1] ^ r_factor[W-1];
            d_q[k]   = d_neg[k] ? -r_quo[k] : r_quo[k];
            // only a positive quotient of magnitude 2^31 falls out of range
            if (!d_neg[k] && r_quo[k][W-1]) begin
                d_over = 1'b1;
            end
        end
    end

    always_comb begin
        res.width         = r_ovf ? r_cur[0] : r_nxt[0];
        res.stretch       = r_ovf ? r_cur[1] : r_nxt[1];
        res.shrink        = r_ovf ? r_cur[2] : r_nxt[2];
        res.stretch_order = r_sto;
        res.shrink_order  = r_sho;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld   <= '0;
            r_limit <= gra_pkg::LIMIT_RESET;
        end else begin
            if (i_cfg_we) begin
                r_limit <= i_cfg_data;
            end
            if (i_cmd.fin) begin
                r_vld[r_idx] <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_op                 <= i_opcode;
            r_idx                <= gra_pkg::IDX_W'(i_reg_index % gra_pkg::NUM_REGS);
            r_in.width           <= {i_in_width[gra_pkg::IN_W-1], i_in_width};
            r_in.stretch         <= {i_in_stretch[gra_pkg::IN_W-1], i_in_stretch};
            r_in.stretch_order   <= i_in_stretch_order;
            r_in.shrink          <= {i_in_shrink[gra_pkg::IN_W-1], i_in_shrink};
            r_in.shrink_order    <= i_in_shrink_order;
            r_factor             <= i_factor;
        end
        if (i_cmd.rd) begin
            r_rd_vld <= r_vld[r_idx];
        end
        if (i_cmd.load) begin
            r_cur[0] <= simple.width;
            r_cur[1] <= simple.stretch;
            r_cur[2] <= simple.shrink;
            r_nxt[0] <= simple.width;
            r_nxt[1] <= simple.stretch;
            r_nxt[2] <= simple.shrink;
            r_sto    <= simple.stretch_order;
            r_sho    <= simple.shrink_order;
            r_ovf    <= 1'b0;
        end
        if (i_cmd.mul_go) begin
            r_prod <= $signed(m_x) * $signed(r_factor);
        end
        if (i_cmd.mul_chk) begin
            if (m_over) begin
                r_ovf <= 1'b1;
            end
            for (int k = 0; k < NC; k++) begin
                if (i_cmd.comp == 2'(k)) begin
                    r_nxt[k] <= r_prod[W-1:0];
                end
            end
        end
        for (int k = 0; k < NC; k++) begin
            if (i_cmd.div_init) begin
                r_rem[k] <= '0;
                r_quo[k] <= r_cur[k][W-1] ? -r_cur[k] : r_cur[k];
            end
            if (i_cmd.div_step) begin
                r_rem[k] <= d_ge[k] ? d_sub[k][W-1:0] : d_t[k][W-1:0];
                r_quo[k] <= {r_quo[k][W-2:0], d_ge[k]};
            end
            if (i_cmd.div_fin) begin
                r_nxt[k] <= d_q[k];
            end
        end
        if (i_cmd.div_fin && d_over) begin
            r_ovf <= 1'b1;
        end
        if (i_cmd.fin) begin
            o_res      <= res;
            o_overflow <= r_ovf;
        end
    end

    assign o_status.op = r_op;

endmodule

`default_nettype wire

// File: hdl/glue_register_arithmetic.sv
// glue register arithmetic top level: controller, datapath, port unpacking
// depends on gra_pkg, gra_ctrl, gra_dpath
//
//   port group   handshake                   carries
//   -----------  --------------------------  ---------------------------------
//   input        i_in_valid / o_in_stall     opcode, index, operand glue, factor
//   result       o_out_valid / i_out_stall   register glue after op, overflow
//   config       i_cfg_valid / o_cfg_ready   scaled_limit
//
// one item at a time: after the accepting edge an item passes the read and load
// states, then for multiply a multiply and a limit check per component on one
// shared 32x32 multiplier, for divide an init, 32 steps in three restoring lanes
// at one quotient bit a cycle and a finish; the result register loads in the fin
// state. reset clears the table through a valid bit per register, no sweep. a
// finished item waits while the result register is full and stalled; the next
// beat is taken once it has moved.
`default_nettype none

module glue_register_arithmetic (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_in_valid,
    output logic                                   o_in_stall,
    input  wire logic [2:0]                        i_opcode,
    input  wire logic [7:0]                        i_reg_index,
    input  wire logic signed [gra_pkg::IN_W-1:0]   i_in_width,
    input  wire logic signed [gra_pkg::IN_W-1:0]   i_in_stretch,
    input  wire logic [gra_pkg::ORD_W-1:0]         i_in_stretch_order,
    input  wire logic signed [gra_pkg::IN_W-1:0]   i_in_shrink,
    input  wire logic [gra_pkg::ORD_W-1:0]         i_in_shrink_order,
    input  wire logic signed [gra_pkg::COMP_W-1:0] i_factor,
    output logic                                   o_out_valid,
    input  wire logic                              i_out_stall,
    output logic signed [gra_pkg::COMP_W-1:0]      o_res_width,
    output logic signed [gra_pkg::COMP_W-1:0]      o_res_stretch,
    output logic [gra_pkg::ORD_W-1:0]              o_res_stretch_order,
    output logic signed [gra_pkg::COMP_W-1:0]      o_res_shrink,
    output logic [gra_pkg::ORD_W-1:0]              o_res_shrink_order,
    output logic                                   o_overflow,
    input  wire logic                              i_cfg_valid,
    output logic                                   o_cfg_ready,
    input  wire logic [gra_pkg::LIMIT_W-1:0]       i_cfg_data
);

    gra_pkg::t_cmd    cmd;
    gra_pkg::t_status status;
    gra_pkg::t_glue   res;

    gra_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_status    (status),
        .o_cmd       (cmd)
    );

    gra_dpath u_dpath (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cmd              (cmd),
        .o_status           (status),
        .i_opcode           (i_opcode),
        .i_reg_index        (i_reg_index),
        .i_in_width         (i_in_width),
        .i_in_stretch       (i_in_stretch),
        .i_in_stretch_order (i_in_stretch_order),
        .i_in_shrink        (i_in_shrink),
        .i_in_shrink_order  (i_in_shrink_order),
        .i_factor           (i_factor),
        .i_cfg_we           (i_cfg_valid),
        .i_cfg_data         (i_cfg_data),
        .o_res              (res),
        .o_overflow         (o_overflow)
    );

    // limit register takes a write in any cycle
    assign o_cfg_ready         = 1'b1;
    assign o_res_width         = res.width;
    assign o_res_stretch       = res.stretch;
    assign o_res_stretch_order = res.stretch_order;
    assign o_res_shrink        = res.shrink;
    assign o_res_shrink_order  = res.shrink_order;

endmodule

`default_nettype wire

// File: hdl/gra_checker.sv
// port-level checks for glue_register_arithmetic, attached by bind
// depends on gra_pkg and the top level's ports
`default_nettype none

module gra_checker (
    input wire logic                              i_clk,
    input wire logic                              i_rst_n,
    input wire logic                              i_in_valid,
    input wire logic                              o_in_stall,
    input wire logic                              o_out_valid,
    input wire logic                              i_out_stall,
    input wire logic signed [gra_pkg::COMP_W-1:0] o_res_width,
    input wire logic signed [gra_pkg::COMP_W-1:0] o_res_stretch,
    input wire logic [gra_pkg::ORD_W-1:0]         o_res_stretch_order,
    input wire logic signed [gra_pkg::COMP_W-1:0] o_res_shrink,
    input wire logic [gra_pkg::ORD_W-1:0]         o_res_shrink_order,
    input wire logic                              o_overflow
);

    logic       in_beat, out_beat;
    logic [1:0] r_pending;

    assign in_beat  = i_in_valid & ~o_in_stall;
    assign out_beat = o_out_valid & ~i_out_stall;

    // items accepted but not yet delivered
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pending <= '0;
        end else begin
            r_pending <= r_pending + {1'b0, in_beat} - {1'b0, out_beat};
        end
    end

    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_beat |=> o_in_stall)
        else $error("input beat taken while an item was still in work");

    a_full_stalls: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_pending == 2'd2) |-> o_in_stall)
        else $error("input open with an item in work and one waiting");

    a_no_phantom: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (r_pending != 2'd0))
        else $error("result beat offered with no item outstanding");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> (o_out_valid && $stable(o_res_width)
            && $stable(o_res_stretch) && $stable(o_res_stretch_order)
            && $stable(o_res_shrink) && $stable(o_res_shrink_order)
            && $stable(o_overflow)))
        else $error("stalled result beat changed or dropped");

endmodule

bind glue_register_arithmetic gra_checker u_gra_checker (.*);

`default_nettype wire

// File: tb/tb_top.sv
// self-checking bench for glue_register_arithmetic: directed and random glue ops
// against an in-bench model of the register table, with random idling on both sides
// depends on gra_pkg and the glue_register_arithmetic rtl
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        logic [2:0]  op;
        logic [7:0]  idx;
        logic [30:0] width;
        logic [30:0] stretch;
        logic [1:0]  stretch_ord;
        logic [30:0] shrink;
        logic [1:0]  shrink_ord;
        logic [31:0] factor;
    } t_glue_op;

    typedef struct {
        logic [31:0] width;
        logic [31:0] stretch;
        logic [1:0]  stretch_ord;
        logic [31:0] shrink;
        logic [1:0]  shrink_ord;
        logic        ovf;
    } t_glue_res;

    localparam logic [30:0] AMT_MAX    = 31'h3FFF_FFFF;
    localparam logic [30:0] AMT_NEGMAX = 31'h4000_0001;
    localparam logic [30:0] AMT_MIN    = 31'h4000_0000;
    localparam logic [31:0] FAC_MIN    = 32'h8000_0000;
    localparam logic [31:0] FAC_MAX    = 32'h7FFF_FFFF;
    localparam logic [31:0] FAC_NEG1   = 32'hFFFF_FFFF;

    logic        i_clk;
    logic        i_rst_n             = 1'b0;
    logic        i_in_valid          = 1'b0;
    logic        o_in_stall;
    logic [2:0]  i_opcode            = '0;
    logic [7:0]  i_reg_index         = '0;
    logic [30:0] i_in_width          = '0;
    logic [30:0] i_in_stretch        = '0;
    logic [1:0]  i_in_stretch_order  = '0;
    logic [30:0] i_in_shrink         = '0;
    logic [1:0]  i_in_shrink_order   = '0;
    logic [31:0] i_factor            = '0;
    logic        o_out_valid;
    logic        i_out_stall         = 1'b0;
    logic [31:0] o_res_width;
    logic [31:0] o_res_stretch;
    logic [1:0]  o_res_stretch_order;
    logic [31:0] o_res_shrink;
    logic [1:0]  o_res_shrink_order;
    logic        o_overflow;
    logic        i_cfg_valid         = 1'b0;
    logic        o_cfg_ready;
    logic [30:0] i_cfg_data          = '0;

    // model of the register table and the limit register
    logic [31:0] width_regs[gra_pkg::NUM_REGS];
    logic [31:0] stretch_regs[gra_pkg::NUM_REGS];
    logic [1:0]  stretch_ord_regs[gra_pkg::NUM_REGS];
    logic [31:0] shrink_regs[gra_pkg::NUM_REGS];
    logic [1:0]  shrink_ord_regs[gra_pkg::NUM_REGS];
    logic [30:0] limit_model;

    t_glue_op  pending_ops[$];
    t_glue_res expected_glue[$];
    t_glue_op  cur_op;
    int        mismatch_count = 0;
    int        send_gap = 0;
    int        stall_left = 0;
    bit        idle_on = 1'b1;

    glue_register_arithmetic DUT (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_in_valid          (i_in_valid),
        .o_in_stall          (o_in_stall),
        .i_opcode            (i_opcode),
        .i_reg_index         (i_reg_index),
        .i_in_width          (i_in_width),
        .i_in_stretch        (i_in_stretch),
        .i_in_stretch_order  (i_in_stretch_order),
        .i_in_shrink         (i_in_shrink),
        .i_in_shrink_order   (i_in_shrink_order),
        .i_factor            (i_factor),
        .o_out_valid         (o_out_valid),
        .i_out_stall         (i_out_stall),
        .o_res_width         (o_res_width),
        .o_res_stretch       (o_res_stretch),
        .o_res_stretch_order (o_res_stretch_order),
        .o_res_shrink        (o_res_shrink),
        .o_res_shrink_order  (o_res_shrink_order),
        .o_overflow          (o_overflow),
        .i_cfg_valid         (i_cfg_valid),
        .o_cfg_ready         (o_cfg_ready),
        .i_cfg_data          (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    initial begin
        #10_000_000;
        $display("tb: failure");
        $finish;
    end

    task automatic report_mismatch(input string msg);
        mismatch_count++;
        $display("mismatch at %0t: %s", $realtime, msg);
    endtask

    // returns {order, amount}: higher nonzero order wins, equal orders add
    function automatic logic [33:0] merge_part(input logic [31:0] amt, input logic [1:0] ord,
                                               input logic [31:0] in_amt,
                                               input logic [1:0] in_ord);
        logic [1:0] o;
        o = (amt == 32'd0) ? 2'd0 : ord;
        if (o == in_ord)
            return {o, amt + in_amt};
        if (o < in_ord && in_amt != 32'd0)
            return {in_ord, in_amt};
        return {o, amt};
    endfunction

    // returns {overflow, product}
    function automatic logic [32:0] scale_comp(input logic [31:0] x, input logic [31:0] f);
        longint p;
        longint lim;
        p   = longint'($signed(x)) * longint'($signed(f));
        lim = longint'({1'b0, limit_model});
        if (p > lim || p < -lim)
            return {1'b1, x};
        return {1'b0, p[31:0]};
    endfunction

    // returns {overflow, quotient}, truncating toward zero
    function automatic logic [32:0] split_comp(input logic [31:0] x, input logic [31:0] f);
        longint q;
        if (f == 32'd0)
            return {1'b1, x};
        q = longint'($signed(x)) / longint'($signed(f));
        if (q > 64'sd2147483647)
            return {1'b1, x};
        return {1'b0, q[31:0]};
    endfunction

    function automatic t_glue_res apply_glue_op(input t_glue_op g);
        t_glue_res   r;
        int          k;
        logic [33:0] part;
        logic [32:0] nw, nst, nsh;
        k             = int'(g.idx) % gra_pkg::NUM_REGS;
        r.width       = width_regs[k];
        r.stretch     = stretch_regs[k];
        r.stretch_ord = stretch_ord_regs[k];
        r.shrink      = shrink_regs[k];
        r.shrink_ord  = shrink_ord_regs[k];
        r.ovf         = 1'b0;
        case (g.op)
            gra_pkg::OP_ASSIGN: begin
                r.width       = {g.width[30], g.width};
                r.stretch     = {g.stretch[30], g.stretch};
                r.stretch_ord = g.stretch_ord;
                r.shrink      = {g.shrink[30], g.shrink};
                r.shrink_ord  = g.shrink_ord;
            end
            gra_pkg::OP_ADVANCE: begin
                r.width = r.width + {g.width[30], g.width};
                part = merge_part(r.stretch, r.stretch_ord, {g.stretch[30], g.stretch},
                                  g.stretch_ord);
                {r.stretch_ord, r.stretch} = part;
                part = merge_part(r.shrink, r.shrink_ord, {g.shrink[30], g.shrink},
                                  g.shrink_ord);
                {r.shrink_ord, r.shrink} = part;
            end
            gra_pkg::OP_MULTIPLY, gra_pkg::OP_DIVIDE: begin
                if (g.op == gra_pkg::OP_MULTIPLY) begin
                    nw  = scale_comp(r.width, g.factor);
                    nst = scale_comp(r.stretch, g.factor);
                    nsh = scale_comp(r.shrink, g.factor);
                end else begin
                    nw  = split_comp(r.width, g.factor);
                    nst = split_comp(r.stretch, g.factor);
                    nsh = split_comp(r.shrink, g.factor);
                end
                r.ovf = nw[32] | nst[32] | nsh[32];
                if (!r.ovf) begin
                    r.width   = nw[31:0];
                    r.stretch = nst[31:0];
                    r.shrink  = nsh[31:0];
                end
            end
            default: begin
                // read and the unused opcodes leave the register alone
            end
        endcase
        width_regs[k]       = r.width;
        stretch_regs[k]     = r.stretch;
        stretch_ord_regs[k] = r.stretch_ord;
        shrink_regs[k]      = r.shrink;
        shrink_ord_regs[k]  = r.shrink_ord;
        return r;
    endfunction

    function automatic t_glue_op make_op(input logic [2:0] op, input logic [7:0] idx,
                                         input logic [30:0] w, input logic [30:0] st,
                                         input logic [1:0] sto, input logic [30:0] sh,
                                         input logic [1:0] sho, input logic [31:0] fac);
        t_glue_op g;
        g.op          = op;
        g.idx         = idx;
        g.width       = w;
        g.stretch     = st;
        g.stretch_ord = sto;
        g.shrink      = sh;
        g.shrink_ord  = sho;
        g.factor      = fac;
        return g;
    endfunction

    function automatic logic [30:0] random_amount();
        int          pick;
        int          v;
        logic [31:0] raw;
        pick = $urandom_range(0, 99);
        raw  = $urandom();
        if (pick < 10)
            return 31'd0;
        if (pick < 50) begin
            v = int'($urandom_range(0, 2000)) - 1000;
            return v[30:0];
        end
        if (pick < 85)
            return raw[30:0];
        case ($urandom_range(0, 3))
            0:       return AMT_MAX;
            1:       return AMT_NEGMAX;
            2:       return AMT_MIN;
            default: return 31'd1;
        endcase
    endfunction

    function automatic logic [31:0] random_factor();
        int pick;
        int v;
        pick = $urandom_range(0, 99);
        if (pick < 30) begin
            v = int'($urandom_range(0, 8)) - 4;
            return v;
        end
        if (pick < 40)
            return 32'd0;
        if (pick < 50)
            return ($urandom_range(0, 1) != 0) ? FAC_NEG1 : 32'd1;
        if (pick < 60)
            return ($urandom_range(0, 1) != 0) ? FAC_MIN : FAC_MAX;
        return $urandom();
    endfunction

    function automatic t_glue_op random_glue_op();
        int       pick;
        t_glue_op g;
        pick = $urandom_range(0, 99);
        if (pick < 15)      g.op = gra_pkg::OP_ASSIGN;
        else if (pick < 30) g.op = gra_pkg::OP_READ;
        else if (pick < 55) g.op = gra_pkg::OP_ADVANCE;
        else if (pick < 75) g.op = gra_pkg::OP_MULTIPLY;
        else if (pick < 95) g.op = gra_pkg::OP_DIVIDE;
        else                g.op = 3'($urandom_range(5, 7));
        // mostly a few hot registers so values build up across ops
        g.idx         = ($urandom_range(0, 9) < 7) ? 8'($urandom_range(0, 7))
                                                   : 8'($urandom_range(0, 255));
        g.width       = random_amount();
        g.stretch     = random_amount();
        g.stretch_ord = 2'($urandom_range(0, 3));
        g.shrink      = random_amount();
        g.shrink_ord  = 2'($urandom_range(0, 3));
        g.factor      = random_factor();
        return g;
    endfunction

    // input side driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
            send_gap = 0;
        end else begin
            if (i_in_valid && !o_in_stall)
                expected_glue.push_back(apply_glue_op(cur_op));
            if (!i_in_valid || !o_in_stall) begin
                if (send_gap > 0) begin
                    send_gap--;
                    i_in_valid <= 1'b0;
                end else if (pending_ops.size() > 0) begin
                    cur_op = pending_ops.pop_front();
                    i_opcode           <= cur_op.op;
                    i_reg_index        <= cur_op.idx;
                    i_in_width         <= cur_op.width;
                    i_in_stretch       <= cur_op.stretch;
                    i_in_stretch_order <= cur_op.stretch_ord;
                    i_in_shrink        <= cur_op.shrink;
                    i_in_shrink_order  <= cur_op.shrink_ord;
                    i_factor           <= cur_op.factor;
                    i_in_valid         <= 1'b1;
                    if (idle_on && $urandom_range(0, 7) == 0)
                        send_gap = $urandom_range(1, 14);
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // result side monitor and stall generator
    always @(posedge i_clk) begin
        t_glue_res want;
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
            stall_left = 0;
        end else begin
            if (o_out_valid && !i_out_stall) begin
                if (expected_glue.size() == 0) begin
                    report_mismatch("result beat with nothing expected");
                end else begin
                    want = expected_glue.pop_front();
                    if (o_res_width !== want.width)
                        report_mismatch($sformatf("width got %h want %h",
                                                  o_res_width, want.width));
                    if (o_res_stretch !== want.stretch)
                        report_mismatch($sformatf("stretch got %h want %h",
                                                  o_res_stretch, want.stretch));
                    if (o_res_stretch_order !== want.stretch_ord)
                        report_mismatch($sformatf("stretch order got %0d want %0d",
                                                  o_res_stretch_order, want.stretch_ord));
                    if (o_res_shrink !== want.shrink)
                        report_mismatch($sformatf("shrink got %h want %h",
                                                  o_res_shrink, want.shrink));
                    if (o_res_shrink_order !== want.shrink_ord)
                        report_mismatch($sformatf("shrink order got %0d want %0d",
                                                  o_res_shrink_order, want.shrink_ord));
                    if (o_overflow !== want.ovf)
                        report_mismatch($sformatf("overflow got %b want %b",
                                                  o_overflow, want.ovf));
                end
            end
            if (stall_left > 0) begin
                stall_left--;
                i_out_stall <= 1'b1;
            end else if (idle_on && $urandom_range(0, 9) == 0) begin
                stall_left = $urandom_range(0, 13);
                i_out_stall <= 1'b1;
            end else begin
                i_out_stall <= 1'b0;
            end
        end
    end

    // sender holds off until every queued op has come back
    // sampled mid-cycle so the driver's updates at the edge have all landed
    task automatic drain_results();
        do @(negedge i_clk);
        while (pending_ops.size() != 0 || i_in_valid || expected_glue.size() != 0);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_scaled_limit(input logic [30:0] value);
        i_cfg_data  <= value;
        i_cfg_valid <= 1'b1;
        do @(posedge i_clk);
        while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        limit_model = value;
    endtask

    task automatic queue_random_ops(input int count);
        repeat (count) pending_ops.push_back(random_glue_op());
    endtask

    initial begin
        for (int k = 0; k < gra_pkg::NUM_REGS; k++) begin
            width_regs[k]       = '0;
            stretch_regs[k]     = '0;
            stretch_ord_regs[k] = '0;
            shrink_regs[k]      = '0;
            shrink_ord_regs[k]  = '0;
        end
        limit_model = gra_pkg::LIMIT_RESET;

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed ops under the reset limit
        pending_ops.push_back(make_op(gra_pkg::OP_READ, 8'd0, 0, 0, 0, 0, 0, 0));
        pending_ops.push_back(make_op(gra_pkg::OP_ASSIGN, 8'd255, AMT_MAX, AMT_MAX, 2'd3,
                                      AMT_MAX, 2'd3, 0));
        pending_ops.push_back(make_op(gra_pkg::OP_ASSIGN, 8'd0, AMT_MIN, AMT_MIN, 2'd0,
                                      AMT_NEGMAX, 2'd2, 0));
        // width and stretch sums reach the most negative word
        pending_ops.push_back(make_op(gra_pkg::OP_ADVANCE, 8'd0, AMT_MIN, AMT_MIN, 2'd0,
                                      AMT_MIN, 2'd2, 0));
        pending_ops.push_back(make_op(gra_pkg::OP_DIVIDE, 8'd0, 0, 0, 0, 0, 0, FAC_NEG1));
        pending_ops.push_back(make_op(gra_pkg::OP_DIVIDE, 8'd0, 0, 0, 0, 0, 0, 32'd0));
        pending_ops.push_back(make_op(gra_pkg::OP_MULTIPLY, 8'd0, 0, 0, 0, 0, 0, 32'd1));
        pending_ops.push_back(make_op(gra_pkg::OP_DIVIDE, 8'd0, 0, 0, 0, 0, 0, 32'd2));
        pending_ops.push_back(make_op(gra_pkg::OP_DIVIDE, 8'd255, 0, 0, 0, 0, 0, 32'd3));
        pending_ops.push_back(make_op(gra_pkg::OP_MULTIPLY, 8'd255, 0, 0, 0, 0, 0, 32'd3));
        pending_ops.push_back(make_op(gra_pkg::OP_MULTIPLY, 8'd255, 0, 0, 0, 0, 0,
                                      -32'sd3));
        pending_ops.push_back(make_op(gra_pkg::OP_ADVANCE, 8'd255, 31'd1, 31'd7, 2'd1,
                                      31'd5, 2'd3, 0));
        // zero stretch with a stored order falls back to finite before merging
        pending_ops.push_back(make_op(gra_pkg::OP_ASSIGN, 8'd5, 31'd1, 31'd0, 2'd2,
                                      31'd7, 2'd1, 0));
        pending_ops.push_back(make_op(gra_pkg::OP_ADVANCE, 8'd5, 31'd2, 31'd9, 2'd1,
                                      31'd0, 2'd3, 0));
        pending_ops.push_back(make_op(gra_pkg::OP_ADVANCE, 8'd5, 31'd0, -31'sd9, 2'd1,
                                      31'd4, 2'd0, 0));
        pending_ops.push_back(make_op(gra_pkg::OP_ADVANCE, 8'd5, 31'd0, 31'd3, 2'd0,
                                      31'd1, 2'd1, 0));
        pending_ops.push_back(make_op(gra_pkg::OP_MULTIPLY, 8'd5, 0, 0, 0, 0, 0, 32'd0));
        pending_ops.push_back(make_op(gra_pkg::OP_MULTIPLY, 8'd6, 0, 0, 0, 0, 0, FAC_MIN));
        pending_ops.push_back(make_op(gra_pkg::OP_ASSIGN, 8'd6, 31'd1, 31'd1, 2'd1,
                                      31'd1, 2'd2, 0));
        pending_ops.push_back(make_op(gra_pkg::OP_MULTIPLY, 8'd6, 0, 0, 0, 0, 0, FAC_MIN));
        pending_ops.push_back(make_op(gra_pkg::OP_MULTIPLY, 8'd6, 0, 0, 0, 0, 0, FAC_MAX));
        pending_ops.push_back(make_op(3'd5, 8'd255, AMT_MAX, 0, 2'd3, 0, 2'd3, FAC_MAX));
        pending_ops.push_back(make_op(3'd6, 8'd0, 0, AMT_MAX, 0, AMT_MIN, 0, 0));
        pending_ops.push_back(make_op(3'd7, 8'd128, AMT_MIN, 0, 2'd1, 0, 2'd2, FAC_MIN));
        pending_ops.push_back(make_op(gra_pkg::OP_DIVIDE, 8'd255, 0, 0, 0, 0, 0, FAC_MIN));
        drain_results();

        write_scaled_limit(31'h7FFF_FFFF);
        queue_random_ops(200);
        drain_results();

        // limit of zero: every nonzero product overflows
        write_scaled_limit(31'd0);
        pending_ops.push_back(make_op(gra_pkg::OP_MULTIPLY, 8'd6, 0, 0, 0, 0, 0, 32'd1));
        pending_ops.push_back(make_op(gra_pkg::OP_MULTIPLY, 8'd5, 0, 0, 0, 0, 0, 32'd5));
        queue_random_ops(60);
        drain_results();

        write_scaled_limit(31'd1);
        queue_random_ops(100);
        drain_results();

        write_scaled_limit(31'($urandom()));
        queue_random_ops(290);
        drain_results();

        // last stretch runs with no idling on either side
        write_scaled_limit(gra_pkg::LIMIT_RESET);
        idle_on = 1'b0;
        queue_random_ops(250);
        drain_results();
        repeat (40) @(posedge i_clk);

        if (mismatch_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

// File: glue_register_arithmetic.f
hdl/gra_pkg.sv
hdl/gra_ram.sv
hdl/gra_ctrl.sv
hdl/gra_dpath.sv
hdl/glue_register_arithmetic.sv
hdl/gra_checker.sv
tb/tb_top.sv
